// ===== design/poly_match_string_kernel_unit_macros.svh =====
// ----------------------------------------------------------------------------
// poly match string kernel assertion macros
// shared concurrent assertion forms, reset-qualified
// ----------------------------------------------------------------------------
`ifndef POLY_MATCH_STRING_KERNEL_UNIT_MACROS_SVH
`define POLY_MATCH_STRING_KERNEL_UNIT_MACROS_SVH

// same-cycle implication
`define PMSK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmsk same-cycle check failed");

// next-cycle implication
`define PMSK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmsk next-cycle check failed");

`endif

// ===== design/pmsk_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsk_pkg
// widths, register codes and shared types of the match string kernel
// ----------------------------------------------------------------------------
package pmsk_pkg;

    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 11;
    localparam int KVAL_W     = 64;
    localparam int DEG_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int FRAC_W     = 32;
    localparam int QDEPTH     = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 2'd2;

    localparam logic [DEG_W-1:0] DEGREE_RST = 3'd2;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             add_one;
        logic             normalize;
    } pmsk_cfg_t;

    // one finished string pair, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] match_cnt;
        logic [CNT_W-1:0] pairs;
        logic             too_long;
    } pmsk_job_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } pmsk_qstat_t;

endpackage

// ===== design/pmsk_if.sv =====
// ----------------------------------------------------------------------------
// pmsk channel interfaces
// valid/ready channels for character pairs and kernel results
// ----------------------------------------------------------------------------
interface pmsk_in_if import pmsk_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_a;
    logic [CHAR_W-1:0] char_b;
    logic              last;

    modport source (output valid, output char_a, output char_b, output last, input ready);
    modport sink   (input valid, input char_a, input char_b, input last, output ready);
endinterface

interface pmsk_out_if import pmsk_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KVAL_W-1:0] kernel_value;
    logic [CNT_W-1:0]  match_count;
    logic              too_long;

    modport source (output valid, output kernel_value, output match_count,
                    output too_long, input ready);
    modport sink   (input valid, input kernel_value, input match_count,
                    input too_long, output ready);
endinterface

// ===== design/pmsk_front.sv =====
// ----------------------------------------------------------------------------
// pmsk_front
// counts pairs and equal positions, hands a job to the queue on the last pair
// ----------------------------------------------------------------------------
module pmsk_front import pmsk_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    pmsk_in_if.sink     pair,
    input  pmsk_qstat_t qstat,
    output logic        push,
    output pmsk_job_t   job
);

    logic [CNT_W-1:0] matches_reg, matches_next;
    logic [CNT_W-1:0] pairs_reg, pairs_next;
    logic             overflow_reg, overflow_next;
    logic             accept;

    // a request is held off only while the queue has no room
    assign pair.ready = !qstat.full;
    assign accept     = pair.valid && pair.ready;

    always_comb
    begin
        matches_next  = matches_reg;
        pairs_next    = pairs_reg;
        overflow_next = overflow_reg;
        if (pairs_reg < CNT_W'(MAX_LEN))
        begin
            pairs_next = pairs_reg + 1'b1;
            if (pair.char_a == pair.char_b)
            begin
                matches_next = matches_reg + 1'b1;
            end
        end
        else
        begin
            overflow_next = 1'b1;
        end
    end

    assign push          = accept && pair.last;
    assign job.match_cnt = matches_next;
    assign job.pairs     = pairs_next;
    assign job.too_long  = overflow_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matches_reg  <= '0;
            pairs_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (pair.last)
            begin
                matches_reg  <= '0;
                pairs_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                matches_reg  <= matches_next;
                pairs_reg    <= pairs_next;
                overflow_reg <= overflow_next;
            end
        end
    end

endmodule

// ===== design/pmsk_queue.sv =====
// ----------------------------------------------------------------------------
// pmsk_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`include "poly_match_string_kernel_unit_macros.svh"

module pmsk_queue import pmsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pmsk_job_t   push_job,
    input  logic        pop,
    output pmsk_job_t   head_job,
    output pmsk_qstat_t qstat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    pmsk_job_t         entry_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign qstat.full  = (count_reg == CNT_QW'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `PMSK_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !qstat.empty)
    `PMSK_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !qstat.full)
    `PMSK_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== design/pmsk_back.sv =====
// ----------------------------------------------------------------------------
// pmsk_back
// forms the kernel value: q32 ratio by long division when normalizing, then power
// ----------------------------------------------------------------------------
`include "poly_match_string_kernel_unit_macros.svh"

module pmsk_back import pmsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pmsk_cfg_t   cfg,
    input  pmsk_qstat_t qstat,
    input  pmsk_job_t   job,
    output logic        pop,
    pmsk_out_if.source  result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POW,
        ST_LOAD
    } state_t;

    localparam int STEP_W = $clog2(FRAC_W);

    state_t            state_reg;
    logic [KVAL_W-1:0] acc_reg;
    logic [FRAC_W:0]   r_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  match_reg;
    logic              too_long_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEG_W-1:0]  pow_cnt_reg;

    logic              out_valid_reg;
    logic [KVAL_W-1:0] out_value_reg;
    logic [CNT_W-1:0]  out_match_reg;
    logic              out_too_long_reg;

    logic [CNT_W-1:0]    n_in;
    logic [CNT_W-1:0]    den_in;
    logic [DEG_W-1:0]    extra_pows;
    logic [CNT_W:0]      rem_shift;
    logic                div_ge;
    logic [KVAL_W-1:0]   acc_div;
    logic [2*FRAC_W-1:0] q_prod;
    logic [KVAL_W-1:0]   i_prod;
    logic                load_norm;

    assign n_in       = job.match_cnt + CNT_W'(cfg.add_one);
    assign den_in     = job.pairs + CNT_W'(cfg.add_one);
    assign extra_pows = (cfg.degree == '0) ? '0 : cfg.degree - 1'b1;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign div_ge    = (rem_shift >= {1'b0, den_reg});
    assign acc_div   = {acc_reg[KVAL_W-2:0], div_ge};

    assign q_prod = acc_reg[FRAC_W-1:0] * r_reg[FRAC_W-1:0];
    assign i_prod = acc_reg * KVAL_W'(n_reg);

    assign pop = (state_reg == ST_IDLE) && !qstat.empty;

    assign load_norm = (state_reg == ST_LOAD) && cfg.normalize;

    assign result.valid        = out_valid_reg;
    assign result.kernel_value = out_value_reg;
    assign result.match_count  = out_match_reg;
    assign result.too_long     = out_too_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            acc_reg          <= '0;
            r_reg            <= '0;
            n_reg            <= '0;
            den_reg          <= '0;
            rem_reg          <= '0;
            match_reg        <= '0;
            too_long_reg     <= 1'b0;
            step_reg         <= '0;
            pow_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
            out_match_reg    <= '0;
            out_too_long_reg <= 1'b0;
        end
        else
        begin
            // in the load state the slot is refilled or kept below
            if (result.ready && (state_reg != ST_LOAD))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        n_reg        <= n_in;
                        den_reg      <= den_in;
                        match_reg    <= job.match_cnt;
                        too_long_reg <= job.too_long;
                        pow_cnt_reg  <= extra_pows;
                        step_reg     <= '0;
                        if (!cfg.normalize)
                        begin
                            acc_reg   <= KVAL_W'(n_in);
                            state_reg <= ST_POW;
                        end
                        else if (den_in == '0)
                        begin
                            acc_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            // n never exceeds den, so the integer bit is n == den
                            acc_reg   <= KVAL_W'(n_in >= den_in);
                            rem_reg   <= (n_in >= den_in) ? n_in - den_in : n_in;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    acc_reg  <= acc_div;
                    rem_reg  <= div_ge ? CNT_W'(rem_shift - {1'b0, den_reg})
                                       : rem_shift[CNT_W-1:0];
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(FRAC_W - 1))
                    begin
                        r_reg     <= acc_div[FRAC_W:0];
                        state_reg <= ST_POW;
                    end
                end
                ST_POW:
                begin
                    if (pow_cnt_reg == '0)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        pow_cnt_reg <= pow_cnt_reg - 1'b1;
                        if (!cfg.normalize)
                        begin
                            acc_reg <= i_prod;
                        end
                        else if (!r_reg[FRAC_W])
                        begin
                            // ratio of exactly one leaves the value unchanged
                            acc_reg <= KVAL_W'(q_prod[2*FRAC_W-1:FRAC_W]);
                        end
                    end
                end
                ST_LOAD:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_value_reg    <= acc_reg;
                        out_match_reg    <= match_reg;
                        out_too_long_reg <= too_long_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `PMSK_ASSERT_IMP(a_rem_below_den, clk, rst_n, state_reg == ST_DIV, rem_reg < den_reg)
    `PMSK_ASSERT_IMP(a_q32_range, clk, rst_n, load_norm, acc_reg <= (KVAL_W'(1) << FRAC_W))

endmodule

// ===== design/poly_match_string_kernel_unit.sv =====
// pair channel: one character pair a cycle, held off only while the job queue is full
// result valid once the last pair's job has passed the queue and back end idle, power, load
// the normalized path adds the bit-serial long division, then one multiply a power
// a new string pair may stream in while the back end still works on the previous one
// reset (rst_n low, asynchronous) clears counters, queue, back end state and the result slot;
// registers return to degree 2, add_one 0, normalize 1
// ----------------------------------------------------------------------------
// poly_match_string_kernel_unit
// polynomial match string kernel: front counter, job queue, power back end
// ----------------------------------------------------------------------------
module poly_match_string_kernel_unit import pmsk_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pmsk_in_if.sink               pair,
    pmsk_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers; the user writes them only while the block is quiet, unenforced
    pmsk_cfg_t   cfg_reg;

    // front to queue
    logic        push;
    pmsk_job_t   push_job;

    // queue to back
    pmsk_job_t   head_job;
    pmsk_qstat_t qstat;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree    <= DEGREE_RST;
            cfg_reg.add_one   <= 1'b0;
            cfg_reg.normalize <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEGREE:    cfg_reg.degree    <= cfg_data[DEG_W-1:0];
                REG_ADD_ONE:   cfg_reg.add_one   <= cfg_data[0];
                REG_NORMALIZE: cfg_reg.normalize <= cfg_data[0];
                default:       ;  // unused index, write dropped
            endcase
        end
    end

    // front: counts each request, emits a job on the last pair of a string
    pmsk_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pair  (pair),
        .qstat (qstat),
        .push  (push),
        .job   (push_job)
    );

    // short queue decouples the character stream from the arithmetic
    pmsk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // back: division to q32 ratio when normalizing, repeated multiply, registered result slot
    pmsk_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .qstat  (qstat),
        .job    (head_job),
        .pop    (pop),
        .result (result)
    );

endmodule
